// ===== rtl/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// rws_pkg: shared types and constants for roulette wheel selection
// Field widths, default parameter values, opcodes and the control structs
// passed between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int SCORE_W = 32;
  localparam int SUM_W   = 40;
  localparam int ROLL_W  = 16;
  localparam int INDEX_W = 7;

  localparam int POP_DEPTH_DEF  = 128;
  localparam int SCORE_FRAC_DEF = 16;
  localparam int ROLL_BITS_DEF  = 16;

  localparam longint START_MIN_INT = 10000;
  localparam longint SCORE_MAX     = 64'sh7FFF_FFFF;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [1:0] {
    ALU_MIN = 2'd0,
    ALU_ACC = 2'd1,
    ALU_GE  = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t                   op;
    logic signed [SCORE_W-1:0] score;
    logic signed [SCORE_W-1:0] minv;
    logic [SUM_W-1:0]          acc;
    logic [SUM_W-1:0]          thr;
    logic [SUM_W-1:0]          unit;
  } alu_req_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] minv;
    logic [SUM_W-1:0]          sum;
    logic                      ge;
  } alu_rsp_t;

  typedef struct packed {
    logic                      action;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
    logic [ROLL_W-1:0]         roll;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               status;
  } result_t;

endpackage

// ===== rtl/rws_if.sv =====
// ----------------------------------------------------------------------------
// rws_if: request and response channels
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface rws_req_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [rws_pkg::SCORE_W-1:0]  score;
  logic                                last;
  logic [rws_pkg::ROLL_W-1:0]          roll;

  modport source (output valid, action, score, last, roll, input ready);
  modport sink   (input valid, action, score, last, roll, output ready);
endinterface

interface rws_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rws_pkg::INDEX_W-1:0]  index;
  logic                         status;

  modport source (output valid, index, status, input ready);
  modport sink   (input valid, index, status, output ready);
endinterface

// ===== rtl/rws_ram.sv =====
// ----------------------------------------------------------------------------
// rws_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rws_alu.sv =====
// ----------------------------------------------------------------------------
// rws_alu: shared add/compare unit
// Minimum update, weight accumulate (acc + score - min + 1.0) and the
// running-sum versus threshold compare of the search.
// ----------------------------------------------------------------------------
module rws_alu (
  input  rws_pkg::alu_req_t req,
  output rws_pkg::alu_rsp_t rsp
);

  logic signed [rws_pkg::SCORE_W+1:0] diff;

  always_comb begin
    rsp  = '0;
    diff = (rws_pkg::SCORE_W+2)'(req.score) - (rws_pkg::SCORE_W+2)'(req.minv);
    case (req.op)
      rws_pkg::ALU_MIN: begin
        rsp.minv = (req.score < req.minv) ? req.score : req.minv;
      end
      rws_pkg::ALU_ACC: begin
        rsp.sum = req.acc + rws_pkg::SUM_W'(unsigned'(diff)) + req.unit;
      end
      rws_pkg::ALU_GE: begin
        rsp.ge = (req.acc >= req.thr);
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule

// ===== rtl/rws_core.sv =====
// ----------------------------------------------------------------------------
// rws_core: wheel sequencer
// Stores scores, walks the store for the minimum and running sums, then
// serves draws with a scaled threshold and a binary search of the sums.
// ----------------------------------------------------------------------------
module rws_core #(
  parameter int POP_DEPTH       = rws_pkg::POP_DEPTH_DEF,
  parameter int SCORE_FRAC_BITS = rws_pkg::SCORE_FRAC_DEF,
  parameter int ROLL_BITS       = rws_pkg::ROLL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  rws_pkg::item_t   item,
  input  logic             res_free,
  output logic             res_valid,
  output rws_pkg::result_t res
);

  localparam int IDX_W  = $clog2(POP_DEPTH);
  localparam int CNT_W  = $clog2(POP_DEPTH + 1);
  localparam int ROLL_U = (ROLL_BITS < rws_pkg::ROLL_W) ? ROLL_BITS : rws_pkg::ROLL_W;
  localparam int PROD_W = ROLL_U + rws_pkg::SUM_W;
  localparam longint START_RAW = rws_pkg::START_MIN_INT << SCORE_FRAC_BITS;
  localparam logic signed [rws_pkg::SCORE_W-1:0] START_MIN =
    (START_RAW > rws_pkg::SCORE_MAX) ? rws_pkg::SCORE_W'(rws_pkg::SCORE_MAX)
                                     : rws_pkg::SCORE_W'(START_RAW);
  localparam logic [rws_pkg::SUM_W-1:0] UNIT =
    rws_pkg::SUM_W'(longint'(1) << SCORE_FRAC_BITS);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_MIN_RD   = 10'b00_0000_0010,
    S_MIN_ACC  = 10'b00_0000_0100,
    S_SUM_RD   = 10'b00_0000_1000,
    S_SUM_ACC  = 10'b00_0001_0000,
    S_MUL      = 10'b00_0010_0000,
    S_THR      = 10'b00_0100_0000,
    S_SRCH_RD  = 10'b00_1000_0000,
    S_SRCH_CMP = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } state_t;

  state_t                            state;
  logic [CNT_W-1:0]                  count;
  logic                              wheel_ready;
  logic [IDX_W-1:0]                  idx;
  logic [IDX_W-1:0]                  lo_i;
  logic [IDX_W-1:0]                  hi_i;
  logic signed [rws_pkg::SCORE_W-1:0] minv;
  logic [rws_pkg::SUM_W-1:0]         acc;
  logic [rws_pkg::SUM_W-1:0]         total;
  logic [rws_pkg::SUM_W-1:0]         thr;
  logic [ROLL_U-1:0]                 roll_r;
  logic [PROD_W-1:0]                 prod;
  rws_pkg::result_t                  res_r;

  logic [CNT_W-1:0]                  eff_count;
  logic [CNT_W-1:0]                  count_after;
  logic                              room;
  logic [IDX_W-1:0]                  last_idx;
  logic [IDX_W-1:0]                  mid;
  logic [PROD_W-1:0]                 rem_mask;
  logic [rws_pkg::SUM_W-1:0]         thr_calc;
  logic                              score_we;
  logic [rws_pkg::SCORE_W-1:0]       score_rdata;
  logic [rws_pkg::SUM_W-1:0]         sum_rdata;
  logic                              sum_we;
  rws_pkg::alu_req_t                 alu_req;
  rws_pkg::alu_rsp_t                 alu_rsp;

  // a load after a finished population starts a new one
  assign eff_count   = wheel_ready ? '0 : count;
  assign room        = (eff_count < CNT_W'(POP_DEPTH));
  assign count_after = eff_count + CNT_W'(room);
  assign last_idx    = IDX_W'(count - CNT_W'(1));
  assign mid         = IDX_W'(({1'b0, lo_i} + {1'b0, hi_i}) >> 1);
  assign rem_mask    = ~({PROD_W{1'b1}} << ROLL_BITS);
  assign thr_calc    = rws_pkg::SUM_W'(prod >> ROLL_BITS)
                     + rws_pkg::SUM_W'(|(prod & rem_mask));

  assign item_ready = (state == S_IDLE);
  assign res_valid  = (state == S_OUT);
  assign res        = res_r;

  assign score_we = (state == S_IDLE) && item_valid &&
                    (item.action == rws_pkg::ACT_LOAD) && room;
  assign sum_we   = (state == S_SUM_ACC);

  rws_ram #(.WIDTH(rws_pkg::SCORE_W), .DEPTH(POP_DEPTH)) u_score_ram (
    .clk   (clk),
    .we    (score_we),
    .waddr (eff_count[IDX_W-1:0]),
    .wdata (item.score),
    .raddr (idx),
    .rdata (score_rdata)
  );

  rws_ram #(.WIDTH(rws_pkg::SUM_W), .DEPTH(POP_DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (idx),
    .wdata (alu_rsp.sum),
    .raddr (mid),
    .rdata (sum_rdata)
  );

  always_comb begin
    alu_req.op    = (state == S_MIN_ACC) ? rws_pkg::ALU_MIN :
                    (state == S_SUM_ACC) ? rws_pkg::ALU_ACC : rws_pkg::ALU_GE;
    alu_req.score = score_rdata;
    alu_req.minv  = minv;
    alu_req.acc   = (state == S_SRCH_CMP) ? sum_rdata : acc;
    alu_req.thr   = thr;
    alu_req.unit  = UNIT;
  end

  rws_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      wheel_ready <= 1'b0;
      total       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.action == rws_pkg::ACT_LOAD) begin
              wheel_ready <= 1'b0;
              count       <= count_after;
              if (item.last) begin
                idx   <= '0;
                minv  <= START_MIN;
                acc   <= '0;
                state <= S_MIN_RD;
              end
            end else begin
              roll_r <= item.roll[ROLL_U-1:0];
              if (!wheel_ready) begin
                res_r.index  <= '0;
                res_r.status <= rws_pkg::STATUS_EMPTY;
                state        <= S_OUT;
              end else begin
                state <= S_MUL;
              end
            end
          end
        end
        S_MIN_RD: begin
          state <= S_MIN_ACC;
        end
        S_MIN_ACC: begin
          minv <= alu_rsp.minv;
          if (idx == last_idx) begin
            idx   <= '0;
            state <= S_SUM_RD;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_MIN_RD;
          end
        end
        S_SUM_RD: begin
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          acc <= alu_rsp.sum;
          if (idx == last_idx) begin
            total       <= alu_rsp.sum;
            wheel_ready <= 1'b1;
            state       <= S_IDLE;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_SUM_RD;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(roll_r) * PROD_W'(total);
          state <= S_THR;
        end
        S_THR: begin
          thr   <= thr_calc;
          lo_i  <= '0;
          hi_i  <= last_idx;
          state <= S_SRCH_RD;
        end
        S_SRCH_RD: begin
          if (lo_i == hi_i) begin
            res_r.index  <= rws_pkg::INDEX_W'(lo_i);
            res_r.status <= rws_pkg::STATUS_OK;
            state        <= S_OUT;
          end else begin
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (alu_rsp.ge) begin
            hi_i <= mid;
          end else begin
            lo_i <= mid + IDX_W'(1);
          end
          state <= S_SRCH_RD;
        end
        S_OUT: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/roulette_wheel_selection_top.sv =====
// ----------------------------------------------------------------------------
// roulette_wheel_selection_top: fitness proportionate selection
// Load words fill a score store; draw words return a selected member index.
// ----------------------------------------------------------------------------
// Load words are taken back to back. The load marked last starts the wheel
// preparation: two walks over the N stored scores through one read port,
// a read state and an accumulate state per member in each walk, during
// which no word is taken. A draw forms its threshold with one multiply,
// then runs a binary search of the running-sum memory, one read and one
// compare per step. A draw before a complete population returns index 0
// with status 1. The response register lets the next word in while a
// result waits.
// ----------------------------------------------------------------------------
module roulette_wheel_selection_top #(
  parameter int POP_DEPTH       = rws_pkg::POP_DEPTH_DEF,
  parameter int SCORE_FRAC_BITS = rws_pkg::SCORE_FRAC_DEF,
  parameter int ROLL_BITS       = rws_pkg::ROLL_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  rws_req_if.sink    req,
  rws_rsp_if.source  rsp
);

  rws_pkg::item_t   item;
  rws_pkg::result_t res;
  logic             res_valid;
  logic             res_free;
  logic             item_ready;
  logic             rsp_valid;
  rws_pkg::result_t rsp_data;

  assign item.action = req.action;
  assign item.score  = req.score;
  assign item.last   = req.last;
  assign item.roll   = req.roll;
  assign req.ready   = item_ready;

  assign res_free   = !rsp_valid || rsp.ready;
  assign rsp.valid  = rsp_valid;
  assign rsp.index  = rsp_data.index;
  assign rsp.status = rsp_data.status;

  rws_core #(
    .POP_DEPTH       (POP_DEPTH),
    .SCORE_FRAC_BITS (SCORE_FRAC_BITS),
    .ROLL_BITS       (ROLL_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (req.valid),
    .item_ready (item_ready),
    .item       (item),
    .res_free   (res_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      rsp_data <= res;
    end
  end

endmodule
